// ===== design/fmmp_pkg.sv =====
// shared types, constants and modular helpers for the fibonacci modulo block
package fmmp_pkg;

    localparam int INDEX_W = 63;
    localparam int VAL_W   = 31;

    localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd100000007;

    // request to the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mm_req_t;

    // response from the shared modular multiplier
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] p;
    } mm_rsp_t;

    // (a + b) mod m for a, b already below m
    function automatic logic [VAL_W-1:0] mod_add(
        input logic [VAL_W-1:0] a,
        input logic [VAL_W-1:0] b,
        input logic [VAL_W-1:0] m
    );
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

// ===== design/fmmp_index_if.sv =====
// item channel that carries the index of the wanted fibonacci number
interface fmmp_index_if;
    logic                         valid;
    logic                         ready;
    logic [fmmp_pkg::INDEX_W-1:0] index;

    modport source (output valid, output index, input ready);
    modport sink (input valid, input index, output ready);
endinterface

// ===== design/fmmp_fib_if.sv =====
// item channel that carries the fibonacci number reduced by the modulus
interface fmmp_fib_if;
    logic                       valid;
    logic                       ready;
    logic [fmmp_pkg::VAL_W-1:0] fib_value;

    modport source (output valid, output fib_value, input ready);
    modport sink (input valid, input fib_value, output ready);
endinterface

// ===== design/fmmp_mulmod.sv =====
// bit-serial modular multiplier: a * b mod m, one bit of b per cycle
module fmmp_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [fmmp_pkg::VAL_W-1:0] modulus,
    input  fmmp_pkg::mm_req_t          req,
    output fmmp_pkg::mm_rsp_t          rsp
);

    localparam int VW    = fmmp_pkg::VAL_W;
    localparam int CNT_W = $clog2(VW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    acc_reg;
    logic [VW-1:0]    a_reg;
    logic [VW-1:0]    b_reg;
    logic [VW-1:0]    acc_next;

    // double the partial result, then add a when the current bit of b is set
    always_comb
    begin
        acc_next = fmmp_pkg::mod_add(
            fmmp_pkg::mod_add(acc_reg, acc_reg, modulus),
            b_reg[VW-1] ? a_reg : '0,
            modulus);
    end

    // control: start, count the bits of b, flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: operands and running remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[VW-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

// ===== design/fibonacci_mod_matrix_power_top.sv =====
// top level: fibonacci number of an index modulo a configured modulus
//
// Each item on index_ch yields exactly one item on fib_ch: F(index) mod modulus,
// with F(0) = 0 and 0 whenever the modulus is 0 or 1. Only the low INDEX_BITS
// bits of the index are used. The index is scanned from its top bit with the
// doubling identities of the matrix power, F(2k) = F(k)(2F(k+1) - F(k)) and
// F(2k+1) = F(k)^2 + F(k+1)^2, so each bit from the highest set bit down costs
// three modular products on one shared bit-serial multiplier; leading zero
// bits of the index are skipped without a product, and a zero modulus skips
// the scan. The block takes one item at a time; ready is high while it is
// idle, also while the previous result still waits in the output register.
// The modulus register resets to 100000007 and must only be written while the
// block is idle.
module fibonacci_mod_matrix_power_top #(
    parameter int INDEX_BITS = 63
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       modulus_we,
    input  logic [fmmp_pkg::VAL_W-1:0] modulus_wdata,
    fmmp_index_if.sink                 index_ch,
    fmmp_fib_if.source                 fib_ch
);

    localparam int VW    = fmmp_pkg::VAL_W;
    localparam int CNT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_WAIT_C,
        ST_WAIT_FF,
        ST_WAIT_GG,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [VW-1:0]           modulus_reg;
    logic [INDEX_BITS-1:0]   n_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    seen_reg;
    logic [VW-1:0]           f_reg;
    logic [VW-1:0]           g_reg;
    logic [VW-1:0]           c_reg;
    logic [VW-1:0]           d_reg;
    logic                    out_valid_reg;
    logic [VW-1:0]           out_value_reg;
    fmmp_pkg::mm_req_t       req_reg;
    fmmp_pkg::mm_rsp_t       rsp;
    logic [VW-1:0]           two_g;
    logic [VW-1:0]           t_val;
    logic [VW:0]             t_wrap;
    logic                    cur_bit;

    fmmp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (req_reg),
        .rsp     (rsp)
    );

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= fmmp_pkg::MODULUS_RESET;
        end
        else if (modulus_we)
        begin
            modulus_reg <= modulus_wdata;
        end
    end

    // t = (2 * F(k+1) - F(k)) mod m
    always_comb
    begin
        two_g  = fmmp_pkg::mod_add(g_reg, g_reg, modulus_reg);
        t_wrap = {1'b0, two_g} + {1'b0, modulus_reg} - {1'b0, f_reg};
        t_val  = (two_g >= f_reg) ? (two_g - f_reg) : t_wrap[VW-1:0];
    end

    assign cur_bit = n_reg[INDEX_BITS-1];

    // sequencer over the index bits, with the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
            seen_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (out_valid_reg && fib_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (index_ch.valid)
                    begin
                        n_reg    <= index_ch.index[INDEX_BITS-1:0];
                        cnt_reg  <= CNT_W'(INDEX_BITS - 1);
                        seen_reg <= 1'b0;
                        f_reg    <= '0;
                        g_reg    <= (modulus_reg == VW'(1)) ? '0 : VW'(1);
                        state_reg <= (modulus_reg == '0) ? ST_FINISH : ST_STEP;
                    end
                end

                ST_STEP:
                begin
                    if (!seen_reg && !cur_bit)
                    begin
                        // leading zero bit leaves F(0), F(1) unchanged
                        n_reg   <= n_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                    else
                    begin
                        seen_reg      <= 1'b1;
                        req_reg.start <= 1'b1;
                        req_reg.a     <= f_reg;
                        req_reg.b     <= t_val;
                        state_reg     <= ST_WAIT_C;
                    end
                end

                ST_WAIT_C:
                begin
                    if (rsp.done)
                    begin
                        c_reg         <= rsp.p;
                        req_reg.start <= 1'b1;
                        req_reg.a     <= f_reg;
                        req_reg.b     <= f_reg;
                        state_reg     <= ST_WAIT_FF;
                    end
                end

                ST_WAIT_FF:
                begin
                    if (rsp.done)
                    begin
                        d_reg         <= rsp.p;
                        req_reg.start <= 1'b1;
                        req_reg.a     <= g_reg;
                        req_reg.b     <= g_reg;
                        state_reg     <= ST_WAIT_GG;
                    end
                end

                ST_WAIT_GG:
                begin
                    if (rsp.done)
                    begin
                        d_reg     <= fmmp_pkg::mod_add(d_reg, rsp.p, modulus_reg);
                        state_reg <= ST_UPDATE;
                    end
                end

                ST_UPDATE:
                begin
                    // c = F(2k), d = F(2k+1)
                    if (cur_bit)
                    begin
                        f_reg <= d_reg;
                        g_reg <= fmmp_pkg::mod_add(c_reg, d_reg, modulus_reg);
                    end
                    else
                    begin
                        f_reg <= c_reg;
                        g_reg <= d_reg;
                    end
                    n_reg   <= n_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    state_reg <= (cnt_reg == '0) ? ST_FINISH : ST_STEP;
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || fib_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= f_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign index_ch.ready   = (state_reg == ST_IDLE);
    assign fib_ch.valid     = out_valid_reg;
    assign fib_ch.fib_value = out_value_reg;

endmodule
